// File: design/mtwh_pkg.sv
// ----------------------------------------------------------------------------
// Multi-slot timer package
// Shared codes, the slot entry layout and the sequencer state type.
// ----------------------------------------------------------------------------
package mtwh_pkg;

	localparam logic [1:0] FUNC_SET  = 2'd0;
	localparam logic [1:0] FUNC_KILL = 2'd1;
	localparam logic [1:0] FUNC_TICK = 2'd2;

	localparam logic [1:0] KIND_SET  = 2'd0;
	localparam logic [1:0] KIND_KILL = 2'd1;
	localparam logic [1:0] KIND_FIRE = 2'd2;

	localparam logic [1:0] ACT_CALLBACK = 2'd0;
	localparam logic [1:0] ACT_SET      = 2'd1;
	localparam logic [1:0] ACT_PULSE    = 2'd2;

	localparam logic STATUS_OK     = 1'b0;
	localparam logic STATUS_CANNOT = 1'b1;

	localparam logic [19:0] TPM_RESET = 20'd10000;
	localparam logic [47:0] IV_MAX    = 48'hFFFF_FFFF_FFFF;

	typedef struct packed {
		logic [15:0] serial;
		logic        periodic;
		logic        sig_set;
		logic        sig_pulse;
		logic [31:0] target;
		logic [31:0] data;
		logic [63:0] fire_time;
		logic [47:0] interval;
	} slot_entry_t;

	typedef enum logic [8:0] {
		ST_IDLE     = 9'b000000001,
		ST_SET_MUL  = 9'b000000010,
		ST_SET_SCAN = 9'b000000100,
		ST_SET_WR   = 9'b000001000,
		ST_KILL_RD  = 9'b000010000,
		ST_KILL_CHK = 9'b000100000,
		ST_TICK_RD  = 9'b001000000,
		ST_TICK_CMP = 9'b010000000,
		ST_TICK_WR  = 9'b100000000
	} state_t;

endpackage

// File: design/multi_slot_timer_with_handles.sv
// ----------------------------------------------------------------------------
// Multi-slot timer with handles
// A table of timer slots that are set, killed and fired one command at a time.
//
// A command is taken when start is high and busy is low. func selects set,
// kill or tick; func 3 is dropped and gives no result. Each result appears
// for exactly one cycle with done high and must be captured then.
// A set scans the allocation bits one slot per cycle after the multiply
// state, then writes the free slot. A kill reads the slot, then checks it.
// A tick reads and compares one slot at a time through the single memory
// port, with a write state for a periodic rearm. Busy stays high for the
// whole command; one command runs at a time. The user writes the time base
// register with cfg_we and cfg_wdata only while idle; the block does not
// enforce this. Reset frees every slot, zeroes the serial counter and restores
// the time base to 10000 units per millisecond. Slot contents need no clearing.
// ----------------------------------------------------------------------------
module multi_slot_timer_with_handles import mtwh_pkg::*; #(
	parameter int SLOTS = 63
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  func,
	input  logic [62:0] now,
	input  logic [31:0] delay_ms,
	input  logic        periodic,
	input  logic        signal_set,
	input  logic        signal_pulse,
	input  logic [31:0] target,
	input  logic [31:0] user_data,
	input  logic [31:0] timer_id,
	input  logic        cfg_we,
	input  logic [19:0] cfg_wdata,
	output logic        done,
	output logic [1:0]  kind,
	output logic [31:0] handle,
	output logic        status,
	output logic [1:0]  action,
	output logic [31:0] fired_target,
	output logic [31:0] fired_data
);

	localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam logic [SW-1:0] LAST = SW'(SLOTS - 1);
	localparam logic [16:0] SLOTS17 = 17'(SLOTS);

	state_t            state_q;
	logic [19:0]       tpm_q;
	logic [15:0]       serial_q;
	logic [SLOTS-1:0]  used_q;
	logic [SW-1:0]     idx_q;
	logic [62:0]       now_q;
	logic [31:0]       delay_q;
	logic              per_q, sset_q, spulse_q;
	logic [31:0]       target_q, data_q, id_q;
	logic              rng_ok_q;
	logic [51:0]       prod_q;
	logic [47:0]       iv_q;

	slot_entry_t       mem [SLOTS];
	slot_entry_t       rdata_q;
	slot_entry_t       wdata;
	logic              mem_we;

	logic [15:0]       kill_low;
	logic [16:0]       kill_s;
	logic [64:0]       set_sum;
	logic [64:0]       rearm_sum;
	logic [15:0]       slot_no;

	assign busy     = (state_q != ST_IDLE);
	assign kill_low = timer_id[15:0];
	assign kill_s   = {1'b0, kill_low} - 17'd1;
	assign set_sum  = {2'b0, now_q} + {17'b0, iv_q};
	assign rearm_sum = {1'b0, rdata_q.fire_time} + {17'b0, rdata_q.interval};
	assign slot_no  = 16'(idx_q) + 16'd1;

	always_comb begin
		mem_we = 1'b0;
		wdata  = rdata_q;
		if (state_q == ST_SET_WR) begin
			mem_we          = 1'b1;
			wdata.serial    = serial_q;
			wdata.periodic  = per_q;
			wdata.sig_set   = sset_q;
			wdata.sig_pulse = spulse_q;
			wdata.target    = target_q;
			wdata.data      = data_q;
			wdata.fire_time = set_sum[63:0];
			wdata.interval  = iv_q;
		end else if (state_q == ST_TICK_WR) begin
			mem_we          = 1'b1;
			wdata.fire_time = rearm_sum[64] ? 64'hFFFF_FFFF_FFFF_FFFF : rearm_sum[63:0];
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[idx_q] <= wdata;
		end
		rdata_q <= mem[idx_q];
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			now_q    <= now;
			delay_q  <= delay_ms;
			per_q    <= periodic;
			sset_q   <= signal_set;
			spulse_q <= signal_pulse;
			target_q <= target;
			data_q   <= user_data;
			id_q     <= timer_id;
			rng_ok_q <= (kill_low != 16'd0) && (kill_s < SLOTS17);
		end
		prod_q <= {20'b0, delay_q} * {32'b0, tpm_q};
		iv_q   <= (prod_q > {4'b0, IV_MAX}) ? IV_MAX : prod_q[47:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			tpm_q        <= TPM_RESET;
			serial_q     <= '0;
			used_q       <= '0;
			idx_q        <= '0;
			done         <= 1'b0;
			kind         <= KIND_SET;
			handle       <= '0;
			status       <= STATUS_OK;
			action       <= ACT_CALLBACK;
			fired_target <= '0;
			fired_data   <= '0;
		end else begin
			done <= 1'b0;
			if (cfg_we) begin
				tpm_q <= cfg_wdata;
			end
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						idx_q <= '0;
						case (func)
							FUNC_SET: state_q <= ST_SET_MUL;
							FUNC_KILL: begin
								state_q <= ST_KILL_RD;
								if ((kill_low != 16'd0) && (kill_s < SLOTS17)) begin
									idx_q <= kill_s[SW-1:0];
								end
							end
							FUNC_TICK: state_q <= ST_TICK_RD;
							default: state_q <= ST_IDLE;
						endcase
					end
				end
				ST_SET_MUL: state_q <= ST_SET_SCAN;
				ST_SET_SCAN: begin
					if (!used_q[idx_q]) begin
						state_q <= ST_SET_WR;
					end else if (idx_q == LAST) begin
						state_q      <= ST_IDLE;
						done         <= 1'b1;
						kind         <= KIND_SET;
						handle       <= '0;
						status       <= STATUS_OK;
						action       <= ACT_CALLBACK;
						fired_target <= '0;
						fired_data   <= '0;
					end else begin
						idx_q <= idx_q + SW'(1);
					end
				end
				ST_SET_WR: begin
					used_q[idx_q] <= 1'b1;
					serial_q      <= serial_q + 16'd1;
					state_q       <= ST_IDLE;
					done          <= 1'b1;
					kind          <= KIND_SET;
					handle        <= {serial_q, slot_no};
					status        <= STATUS_OK;
					action        <= ACT_CALLBACK;
					fired_target  <= '0;
					fired_data    <= '0;
				end
				ST_KILL_RD: state_q <= ST_KILL_CHK;
				ST_KILL_CHK: begin
					state_q      <= ST_IDLE;
					done         <= 1'b1;
					kind         <= KIND_KILL;
					handle       <= id_q;
					action       <= ACT_CALLBACK;
					fired_target <= '0;
					fired_data   <= '0;
					if (rng_ok_q && used_q[idx_q] && (rdata_q.serial == id_q[31:16])) begin
						used_q[idx_q] <= 1'b0;
						status        <= STATUS_OK;
					end else begin
						status <= STATUS_CANNOT;
					end
				end
				ST_TICK_RD: state_q <= ST_TICK_CMP;
				ST_TICK_CMP: begin
					if (used_q[idx_q] && (rdata_q.fire_time <= {1'b0, now_q})) begin
						done         <= 1'b1;
						kind         <= KIND_FIRE;
						handle       <= {rdata_q.serial, slot_no};
						status       <= STATUS_OK;
						fired_target <= rdata_q.target;
						fired_data   <= rdata_q.data;
						if (rdata_q.sig_set) begin
							action <= ACT_SET;
						end else if (rdata_q.sig_pulse) begin
							action <= ACT_PULSE;
						end else begin
							action <= ACT_CALLBACK;
						end
						if (rdata_q.periodic) begin
							state_q <= ST_TICK_WR;
						end else begin
							used_q[idx_q] <= 1'b0;
							state_q       <= ST_IDLE;
						end
					end else if (idx_q == LAST) begin
						state_q <= ST_IDLE;
					end else begin
						idx_q   <= idx_q + SW'(1);
						state_q <= ST_TICK_RD;
					end
				end
				ST_TICK_WR: state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// File: design/mtwh_checker.sv
// ----------------------------------------------------------------------------
// Multi-slot timer port checker
// Checks the result strobe and the result fields seen at the top level ports.
// ----------------------------------------------------------------------------
module mtwh_port_props import mtwh_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        busy,
	input logic        done,
	input logic [1:0]  kind,
	input logic        status,
	input logic [1:0]  action,
	input logic [31:0] fired_target,
	input logic [31:0] fired_data
);

	// A result always closes a command that was running in the previous cycle.
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result without a running command");

	a_kind_legal: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (kind == KIND_SET || kind == KIND_KILL || kind == KIND_FIRE))
		else $error("illegal result kind");

	a_status_kill_only: assert property (@(posedge clk) disable iff (!arst_n)
		(done && kind != KIND_KILL) |-> (status == STATUS_OK))
		else $error("status set outside a kill reply");

	a_reply_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(done && kind != KIND_FIRE) |->
			(action == ACT_CALLBACK && fired_target == '0 && fired_data == '0))
		else $error("fire fields set in a reply");

endmodule

bind multi_slot_timer_with_handles mtwh_port_props u_mtwh_port_props (
	.clk(clk),
	.arst_n(arst_n),
	.busy(busy),
	.done(done),
	.kind(kind),
	.status(status),
	.action(action),
	.fired_target(fired_target),
	.fired_data(fired_data)
);

// File: tb/sv/mtwh_checker.sv
// ----------------------------------------------------------------------------
// Multi-slot timer scoreboard
// Watches the command, configuration and result ports of the timer table.
// It keeps its own copy of the slot table, predicts the result of every
// accepted transaction, and compares each result field by field.
// ----------------------------------------------------------------------------
module mtwh_checker import mtwh_pkg::*; #(
	parameter int SLOTS = 63
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  logic [1:0]  func,
	input  logic [62:0] now,
	input  logic [31:0] delay_ms,
	input  logic        periodic,
	input  logic        signal_set,
	input  logic        signal_pulse,
	input  logic [31:0] target,
	input  logic [31:0] user_data,
	input  logic [31:0] timer_id,
	input  logic        cfg_we,
	input  logic [19:0] cfg_wdata,
	input  logic        done,
	input  logic [1:0]  kind,
	input  logic [31:0] handle,
	input  logic        status,
	input  logic [1:0]  action,
	input  logic [31:0] fired_target,
	input  logic [31:0] fired_data,
	output int          errors,
	output int          pending,
	output int          fires_seen,
	output int          results_seen
);

	typedef struct packed {
		logic [1:0]  kind;
		logic [31:0] handle;
		logic        status;
		logic [1:0]  action;
		logic [31:0] tgt;
		logic [31:0] dat;
	} reply_t;

	reply_t      replies_due[$];
	logic [19:0] time_base;
	logic        in_use    [SLOTS];
	slot_entry_t slot_table[SLOTS];
	logic [15:0] serial_ctr;

	function automatic logic [15:0] low_slot(int s);
		return 16'(s + 1);
	endfunction

	task automatic predict_command();
		reply_t      r;
		logic [63:0] product;
		logic [47:0] span;
		logic [64:0] sum;
		logic [15:0] lo;
		bit          found;
		r = '0;
		found = 0;
		case (func)
			FUNC_SET: begin
				r.kind = KIND_SET;
				for (int s = 0; s < SLOTS && !found; s++) begin
					if (!in_use[s]) begin
						found = 1;
						product = 64'(delay_ms) * 64'(time_base);
						span = (product > 64'(IV_MAX)) ? IV_MAX : product[47:0];
						in_use[s] = 1'b1;
						slot_table[s].serial = serial_ctr;
						slot_table[s].periodic = periodic;
						slot_table[s].sig_set = signal_set;
						slot_table[s].sig_pulse = signal_pulse;
						slot_table[s].target = target;
						slot_table[s].data = user_data;
						slot_table[s].interval = span;
						slot_table[s].fire_time = 64'(now) + 64'(span);
						r.handle = {serial_ctr, low_slot(s)};
						serial_ctr = serial_ctr + 16'd1;
					end
				end
				replies_due.push_back(r);
			end
			FUNC_KILL: begin
				r.kind = KIND_KILL;
				r.handle = timer_id;
				r.status = STATUS_CANNOT;
				lo = timer_id[15:0];
				if (lo != 0 && int'(lo) <= SLOTS) begin
					if (in_use[lo - 1] && slot_table[lo - 1].serial == timer_id[31:16]) begin
						in_use[lo - 1] = 1'b0;
						r.status = STATUS_OK;
					end
				end
				replies_due.push_back(r);
			end
			FUNC_TICK: begin
				for (int s = 0; s < SLOTS && !found; s++) begin
					if (in_use[s] && slot_table[s].fire_time <= 64'(now)) begin
						found = 1;
						r.kind = KIND_FIRE;
						r.handle = {slot_table[s].serial, low_slot(s)};
						r.action = slot_table[s].sig_set ? ACT_SET :
							(slot_table[s].sig_pulse ? ACT_PULSE : ACT_CALLBACK);
						r.tgt = slot_table[s].target;
						r.dat = slot_table[s].data;
						if (slot_table[s].periodic) begin
							sum = 65'(slot_table[s].fire_time) + 65'(slot_table[s].interval);
							slot_table[s].fire_time = sum[64] ? '1 : sum[63:0];
						end else begin
							in_use[s] = 1'b0;
						end
						replies_due.push_back(r);
					end
				end
			end
			default: begin
			end
		endcase
	endtask

	task automatic compare_reply();
		reply_t exp_r;
		reply_t got;
		got = '{kind, handle, status, action, fired_target, fired_data};
		results_seen++;
		if (kind == KIND_FIRE)
			fires_seen++;
		if (replies_due.size() == 0) begin
			$display("%0t: unexpected result %h", $time, got);
			errors++;
		end else begin
			exp_r = replies_due.pop_front();
			if (got.kind != exp_r.kind) begin
				$display("%0t: kind expected %0d actual %0d", $time, exp_r.kind, got.kind);
				errors++;
			end
			if (got.handle != exp_r.handle) begin
				$display("%0t: handle expected %h actual %h", $time, exp_r.handle, got.handle);
				errors++;
			end
			if (got.status != exp_r.status) begin
				$display("%0t: status expected %0d actual %0d", $time, exp_r.status,
					got.status);
				errors++;
			end
			if (got.action != exp_r.action) begin
				$display("%0t: action expected %0d actual %0d", $time, exp_r.action,
					got.action);
				errors++;
			end
			if (got.tgt != exp_r.tgt) begin
				$display("%0t: fired_target expected %h actual %h", $time, exp_r.tgt, got.tgt);
				errors++;
			end
			if (got.dat != exp_r.dat) begin
				$display("%0t: fired_data expected %h actual %h", $time, exp_r.dat, got.dat);
				errors++;
			end
		end
	endtask

	initial begin
		errors = 0;
		pending = 0;
		fires_seen = 0;
		results_seen = 0;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_base = TPM_RESET;
			serial_ctr = '0;
			for (int s = 0; s < SLOTS; s++)
				in_use[s] = 1'b0;
			replies_due.delete();
			pending = 0;
		end else begin
			if (done)
				compare_reply();
			if (cfg_we)
				time_base = cfg_wdata;
			if (start && !busy)
				predict_command();
			pending = replies_due.size();
		end
	end

endmodule

// File: tb/sv/tb_multi_slot_timer_with_handles.sv
// ----------------------------------------------------------------------------
// Multi-slot timer testbench
// Drives set, kill and tick commands into the timer table, first a directed
// list of corner cases and then random phases under several time bases and
// idle patterns, while the scoreboard checks every result.
// ----------------------------------------------------------------------------
module tb_multi_slot_timer_with_handles;
	import mtwh_pkg::*;

	localparam logic [1:0] FUNC_NONE = 2'd3;
	localparam int SETTLE = 140;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic [1:0]  func = FUNC_SET;
	logic [62:0] now = '0;
	logic [31:0] delay_ms = '0;
	logic        periodic = 1'b0;
	logic        signal_set = 1'b0;
	logic        signal_pulse = 1'b0;
	logic [31:0] target = '0;
	logic [31:0] user_data = '0;
	logic [31:0] timer_id = '0;
	logic        cfg_we = 1'b0;
	logic [19:0] cfg_wdata = '0;
	logic        done;
	logic [1:0]  kind;
	logic [31:0] handle;
	logic        status;
	logic [1:0]  action;
	logic [31:0] fired_target;
	logic [31:0] fired_data;
	int          errors;
	int          pending;
	int          fires_seen;
	int          results_seen;

	logic [31:0] live_handles[$];
	logic [63:0] clock_now;
	logic [19:0] base_now;
	int          sent;

	multi_slot_timer_with_handles uut (.*);
	mtwh_checker chk (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk)
		if (done && kind == KIND_SET && handle != 0)
			live_handles.push_back(handle);

	task automatic issue(logic [1:0] f, logic [62:0] t, logic [31:0] d, logic [2:0] m,
		logic [31:0] tg, logic [31:0] ud, logic [31:0] id);
		func <= f;
		now <= t;
		delay_ms <= d;
		{periodic, signal_set, signal_pulse} <= m;
		target <= tg;
		user_data <= ud;
		timer_id <= id;
		start <= 1'b1;
		do
			@(posedge clk);
		while (busy);
		sent++;
	endtask

	task automatic pause_start(int n);
		start <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	task automatic drain();
		start <= 1'b0;
		do
			@(posedge clk);
		while (pending != 0 || busy);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_base(logic [19:0] v);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		base_now = v;
	endtask

	task automatic random_item(int set_pct);
		int          pick;
		int          k;
		logic [62:0] t;
		logic [31:0] d;
		logic [31:0] id;
		logic [1:0]  f;
		pick = $urandom_range(99);
		clock_now = clock_now + 64'($urandom_range(0, 3)) * 64'(base_now)
			+ 64'($urandom_range(0, 7));
		t = clock_now[62:0];
		if ($urandom_range(19) == 0)
			t = 63'({$urandom, $urandom});
		d = ($urandom_range(9) == 0) ? $urandom : 32'($urandom_range(0, 5));
		id = $urandom;
		if (pick < set_pct)
			f = FUNC_SET;
		else if (pick < set_pct + (100 - set_pct) / 3)
			f = FUNC_KILL;
		else if (pick < 96)
			f = FUNC_TICK;
		else
			f = FUNC_NONE;
		if (f == FUNC_KILL && live_handles.size() != 0 && $urandom_range(4) != 0) begin
			k = $urandom_range(live_handles.size() - 1);
			id = live_handles[k];
			if ($urandom_range(4) != 0)
				live_handles.delete(k);
			else if ($urandom_range(1) == 0)
				id[31:16] = id[31:16] ^ 16'(1 << $urandom_range(15));
		end
		issue(f, t, d, 3'($urandom), $urandom, $urandom, id);
	endtask

	initial begin
		automatic logic [19:0] bases[6] = '{20'd1, 20'hFFFFF, 20'd0, 20'd1000000, 20'd3,
			TPM_RESET};
		automatic int idle_pct[6] = '{0, 61, 34, 61, 0, 34};
		sent = 0;
		clock_now = 64'd200;
		base_now = TPM_RESET;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		write_base(20'd1);

		issue(FUNC_SET, 63'd100, 32'd0, 3'b000, 32'hFFFF_FFFF, 32'h0000_0000, '0);
		issue(FUNC_SET, 63'd100, 32'd0, 3'b010, 32'h0000_0000, 32'hFFFF_FFFF, '0);
		issue(FUNC_SET, 63'd100, 32'd0, 3'b001, 32'hA5A5_5A5A, 32'h5A5A_A5A5, '0);
		issue(FUNC_SET, 63'd100, 32'd0, 3'b111, 32'h1234_5678, 32'h8765_4321, '0);
		issue(FUNC_SET, 63'd0, 32'hFFFF_FFFF, 3'b100, 32'd1, 32'd2, '0);
		issue(FUNC_SET, '1, 32'd5, 3'b011, 32'd3, 32'd4, '0);
		issue(FUNC_TICK, 63'd0, '0, '0, '0, '0, '0);
		issue(FUNC_TICK, 63'd100, '0, '0, '0, '0, '0);
		issue(FUNC_TICK, 63'd100, '0, '0, '0, '0, '0);
		issue(FUNC_TICK, 63'd100, '0, '0, '0, '0, '0);
		issue(FUNC_TICK, 63'd100, '0, '0, '0, '0, '0);
		issue(FUNC_KILL, '0, '0, '0, '0, '0, 32'h0000_0000);
		issue(FUNC_KILL, '0, '0, '0, '0, '0, 32'h0000_FFFF);
		issue(FUNC_KILL, '0, '0, '0, '0, '0, 32'h0000_0040);
		issue(FUNC_KILL, '0, '0, '0, '0, '0, 32'h0000_0001);
		issue(FUNC_KILL, '0, '0, '0, '0, '0, 32'hFFFF_0003);
		issue(FUNC_KILL, '0, '0, '0, '0, '0, 32'h0003_0004);
		issue(FUNC_NONE, '1, '1, '1, '1, '1, '1);
		issue(FUNC_TICK, '1, '0, '0, '0, '0, '0);
		issue(FUNC_TICK, '1, '0, '0, '0, '0, '0);
		issue(FUNC_TICK, '1, '0, '0, '0, '0, '0);
		issue(FUNC_KILL, '0, '0, '0, '0, '0, 32'h0002_0003);
		drain();

		for (int p = 0; p < 6; p++) begin
			write_base(bases[p]);
			for (int n = 0; n < 230; n++) begin
				random_item((p == 3) ? 75 : 35);
				if (n % 60 == 59)
					drain();
				else if (idle_pct[p] != 0 && $urandom_range(99) < idle_pct[p])
					pause_start($urandom_range(1, 6));
			end
			drain();
		end

		$display("Covered %0d transactions under %0d time-base settings and three idle patterns.",
			sent, 6);
		$display("The scoreboard checked %0d results, %0d of them timer fires.",
			results_seen, fires_seen);
		if (errors == 0)
			$display("tb_multi_slot_timer_with_handles passed");
		else
			$display("tb_multi_slot_timer_with_handles failed");
		$finish;
	end

	initial begin
		#10000000;
		$display("tb_multi_slot_timer_with_handles failed");
		$finish;
	end

endmodule

// File: files.f
design/mtwh_pkg.sv
design/multi_slot_timer_with_handles.sv
design/mtwh_checker.sv
tb/sv/mtwh_checker.sv
tb/sv/tb_multi_slot_timer_with_handles.sv
